### hdl/daoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daoa_pkg
// Shared widths, codes and control types of the dual ADC offset averager.
// ----------------------------------------------------------------------------
package daoa_pkg;

  localparam int CHAN_W     = 16;
  localparam int TIMER_W    = 16;
  localparam int WINDOW_W   = 24;
  localparam int ELAPSED_W  = 25;
  localparam int OFFSET_W   = 16;
  localparam int USED_W     = 24;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd480000;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_LOAD
  } daoa_state_t;

  typedef struct packed {
    logic start;
    logic acc;
    logic div_load;
    logic div_step;
    logic out_load;
  } daoa_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic armed;
    logic close;
  } daoa_stat_t;

endpackage

### hdl/daoa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daoa channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface daoa_in_if
  import daoa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [CHAN_W-1:0]  chan_a;
  logic [CHAN_W-1:0]  chan_b;
  logic [TIMER_W-1:0] timer_now;

  modport source (output valid, req_type, chan_a, chan_b, timer_now, input ready);
  modport sink   (input valid, req_type, chan_a, chan_b, timer_now, output ready);
endinterface

interface daoa_out_if
  import daoa_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] offset_a;
  logic [OFFSET_W-1:0] offset_b;
  logic [USED_W-1:0]   samples_used;
  logic                count_limited;

  modport source (output valid, offset_a, offset_b, samples_used, count_limited,
                  input ready);
  modport sink   (input valid, offset_a, offset_b, samples_used, count_limited,
                  output ready);
endinterface

interface daoa_cfg_if
  import daoa_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [WINDOW_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hdl/daoa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daoa_ctrl
// Sequencer: accepts items, runs the shared-count divide, loads the result.
// ----------------------------------------------------------------------------
module daoa_ctrl
  import daoa_pkg::*;
#(
  parameter int SUM_W = 40
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  daoa_stat_t stat,
  output daoa_cmd_t  cmd
);

  localparam int CNT_W = $clog2(SUM_W);

  daoa_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!stat.is_sample) begin
            cmd.start = 1'b1;
          end else if (stat.armed) begin
            cmd.acc = 1'b1;
            if (stat.close) begin
              state_nxt = ST_PREP;
            end
          end
        end
      end
      ST_PREP: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SUM_W - 1)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hdl/daoa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daoa_dp
// Accumulators, window timing, restoring dividers and result registers.
// ----------------------------------------------------------------------------
module daoa_dp
  import daoa_pkg::*;
#(
  parameter int COUNT_BITS  = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_type,
  input  logic [CHAN_W-1:0]   chan_a,
  input  logic [CHAN_W-1:0]   chan_b,
  input  logic [TIMER_W-1:0]  timer_now,
  input  logic                cfg_we,
  input  logic [WINDOW_W-1:0] cfg_data,
  input  daoa_cmd_t           cmd,
  output daoa_stat_t          stat,
  output logic [OFFSET_W-1:0] offset_a,
  output logic [OFFSET_W-1:0] offset_b,
  output logic [USED_W-1:0]   samples_used,
  output logic                count_limited
);

  localparam int SUM_W = COUNT_BITS + SAMPLE_BITS;

  logic [WINDOW_W-1:0]    window_r;
  logic                   armed_r;
  logic [SUM_W-1:0]       sum_a_r, sum_b_r, sum_a_nxt, sum_b_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;
  logic [TIMER_W-1:0]     last_r, delta;
  logic                   limited_r;
  logic                   time_up, count_full;

  logic [SUM_W-1:0]       dvd_a_r, dvd_b_r;
  logic [COUNT_BITS-1:0]  rem_a_r, rem_b_r;
  logic [COUNT_BITS:0]    sh_a, sh_b;
  logic [COUNT_BITS+1:0]  dif_a, dif_b;

  logic [OFFSET_W-1:0]    offset_a_r, offset_b_r;
  logic [USED_W-1:0]      used_r;
  logic                   out_limited_r;

  assign delta       = timer_now - last_r;
  assign sum_a_nxt   = sum_a_r + SUM_W'(SAMPLE_BITS'(chan_a));
  assign sum_b_nxt   = sum_b_r + SUM_W'(SAMPLE_BITS'(chan_b));
  assign count_nxt   = count_r + 1'b1;
  assign elapsed_nxt = elapsed_r + ELAPSED_W'(delta);
  assign time_up     = elapsed_nxt >= ELAPSED_W'(window_r);
  assign count_full  = &count_nxt;

  assign stat.is_sample = (req_type == REQ_SAMPLE);
  assign stat.armed     = armed_r;
  assign stat.close     = time_up || count_full;

  // one restoring step per cycle, quotient shifts into the dividend
  assign sh_a  = {rem_a_r, dvd_a_r[SUM_W-1]};
  assign sh_b  = {rem_b_r, dvd_b_r[SUM_W-1]};
  assign dif_a = {1'b0, sh_a} - {2'b00, count_r};
  assign dif_b = {1'b0, sh_b} - {2'b00, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      armed_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_data;
      end
      if (cmd.start) begin
        armed_r <= 1'b1;
      end else if (cmd.acc && stat.close) begin
        armed_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum_a_r   <= '0;
      sum_b_r   <= '0;
      count_r   <= '0;
      elapsed_r <= '0;
      last_r    <= timer_now;
    end else if (cmd.acc) begin
      sum_a_r   <= sum_a_nxt;
      sum_b_r   <= sum_b_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
      last_r    <= timer_now;
      limited_r <= !time_up;
    end

    if (cmd.div_load) begin
      dvd_a_r <= sum_a_r;
      dvd_b_r <= sum_b_r;
      rem_a_r <= '0;
      rem_b_r <= '0;
    end else if (cmd.div_step) begin
      if (!dif_a[COUNT_BITS+1]) begin
        rem_a_r <= dif_a[COUNT_BITS-1:0];
        dvd_a_r <= {dvd_a_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_a_r <= sh_a[COUNT_BITS-1:0];
        dvd_a_r <= {dvd_a_r[SUM_W-2:0], 1'b0};
      end
      if (!dif_b[COUNT_BITS+1]) begin
        rem_b_r <= dif_b[COUNT_BITS-1:0];
        dvd_b_r <= {dvd_b_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_b_r <= sh_b[COUNT_BITS-1:0];
        dvd_b_r <= {dvd_b_r[SUM_W-2:0], 1'b0};
      end
    end

    if (cmd.out_load) begin
      if (count_r == '0) begin
        offset_a_r <= '0;
        offset_b_r <= '0;
      end else begin
        offset_a_r <= dvd_a_r[OFFSET_W-1:0];
        offset_b_r <= dvd_b_r[OFFSET_W-1:0];
      end
      used_r        <= USED_W'(count_r);
      out_limited_r <= limited_r;
    end
  end

  assign offset_a      = offset_a_r;
  assign offset_b      = offset_b_r;
  assign samples_used  = used_r;
  assign count_limited = out_limited_r;

endmodule

### hdl/dual_adc_offset_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_adc_offset_averager
// Zero-current offset averaging for two current-sense ADC channels.
// ----------------------------------------------------------------------------
// A start item (req_type 0) latches the timer and arms a new window; each
// sample item (req_type 1) adds both readings, one count and the wrapped
// timer delta. When elapsed ticks reach window_ticks, or the count
// saturates first (count_limited set), the closing sample starts a bit-serial
// restoring divide of both sums by the count, one quotient bit per cycle in
// two parallel lanes: in_ready is low through the prep, divide and load
// states, plus any wait for the previous result to be taken. The result sits
// in an output register, so input transfers go on while it waits. Samples
// while disarmed are dropped without a result.
// ----------------------------------------------------------------------------
module dual_adc_offset_averager
  import daoa_pkg::*;
#(
  parameter int COUNT_BITS  = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  daoa_in_if.sink     in_ch,
  daoa_out_if.source  out_ch,
  daoa_cfg_if.sink    cfg_ch
);

  daoa_cmd_t  cmd;
  daoa_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  daoa_ctrl #(
    .SUM_W (COUNT_BITS + SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  daoa_dp #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_type      (in_ch.req_type),
    .chan_a        (in_ch.chan_a),
    .chan_b        (in_ch.chan_b),
    .timer_now     (in_ch.timer_now),
    .cfg_we        (cfg_ch.valid),
    .cfg_data      (cfg_ch.data),
    .cmd           (cmd),
    .stat          (stat),
    .offset_a      (out_ch.offset_a),
    .offset_b      (out_ch.offset_b),
    .samples_used  (out_ch.samples_used),
    .count_limited (out_ch.count_limited)
  );

endmodule

### hdl/daoa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daoa_checker
// Port-level checks of the offset averager, bound to the top level.
// ----------------------------------------------------------------------------
module daoa_checker
  import daoa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_req_type,
  input logic              out_valid,
  input logic              out_ready,
  input logic [USED_W-1:0] out_samples_used,
  input logic              out_count_limited
);

  // busy only after a sample transfer closed a window
  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_req_type == REQ_SAMPLE))
    else $error("input stalled without a closing sample transfer");

  // a new result follows the divide, never an idle cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a divide");

  // saturated count shows as all ones in the low bits
  a_limited_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count_limited) |-> (out_samples_used[7:0] == 8'hFF))
    else $error("count_limited with unsaturated count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

endmodule

bind dual_adc_offset_averager daoa_checker u_daoa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_req_type       (in_ch.req_type),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_samples_used  (out_ch.samples_used),
  .out_count_limited (out_ch.count_limited)
);

### sim/tb_dual_adc_offset_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_adc_offset_averager
// Self-checking bench for the dual ADC offset averager. A cycle-free model of
// the window logic predicts every offset result when its input is taken. Each
// result transfer is checked field by field against the oldest prediction.
// Directed tests come first: disarmed samples, restarts, timer wrap, a zero
// window, a one-tick window, the widest window and a long result hold-off.
// Randomized windows over several register settings follow, with random
// idling on both channels except in the quiet phases.
// ----------------------------------------------------------------------------
module tb_dual_adc_offset_averager;
  import daoa_pkg::*;

  localparam int RESULT_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES      = 64;
  localparam int DRAIN_LIMIT        = 5000;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_a;
    logic [OFFSET_W-1:0] offset_b;
    logic [USED_W-1:0]   samples_used;
    logic                count_limited;
  } offset_result_t;

  logic clk = 1'b0;
  logic rst_n;

  daoa_in_if  in_ch ();
  daoa_out_if out_ch ();
  daoa_cfg_if cfg_ch ();

  dual_adc_offset_averager DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // window tracker state
  logic [39:0]          acc_a;
  logic [39:0]          acc_b;
  logic [23:0]          pair_count;
  logic [ELAPSED_W-1:0] elapsed;
  logic [TIMER_W-1:0]   last_timer;
  logic                 armed;
  logic [WINDOW_W-1:0]  window_ticks;

  offset_result_t pending_offsets[$];

  int  error_count   = 0;
  int  n_taken       = 0;
  int  n_ignored     = 0;
  int  n_checked     = 0;
  int  n_settings    = 0;
  bit  no_idle       = 1'b0;
  bit  result_hold_req = 1'b0;

  function automatic bit step_window(input logic kind, input logic [CHAN_W-1:0] a,
                                     input logic [CHAN_W-1:0] b,
                                     input logic [TIMER_W-1:0] t,
                                     output offset_result_t res);
    logic [TIMER_W-1:0] delta;
    logic [39:0]        quo_a;
    logic [39:0]        quo_b;
    logic               time_up;
    logic               count_full;
    res = '0;
    if (kind == REQ_START) begin
      acc_a      = '0;
      acc_b      = '0;
      pair_count = '0;
      elapsed    = '0;
      last_timer = t;
      armed      = 1'b1;
      return 1'b0;
    end
    if (!armed) return 1'b0;
    acc_a      = acc_a + {24'd0, a};
    acc_b      = acc_b + {24'd0, b};
    pair_count = pair_count + 24'd1;
    delta      = t - last_timer;
    elapsed    = elapsed + {{(ELAPSED_W-TIMER_W){1'b0}}, delta};
    last_timer = t;
    time_up    = elapsed >= {1'b0, window_ticks};
    count_full = pair_count == '1;
    if (!time_up && !count_full) return 1'b0;
    if (pair_count != 0) begin
      quo_a = acc_a / {16'd0, pair_count};
      quo_b = acc_b / {16'd0, pair_count};
      res.offset_a = quo_a[OFFSET_W-1:0];
      res.offset_b = quo_b[OFFSET_W-1:0];
    end
    res.samples_used  = pair_count;
    res.count_limited = !time_up;
    armed = 1'b0;
    return 1'b1;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAN_W-1:0] reading();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 30) return 16'(32768 + $urandom_range(0, 400) - 200);
    return 16'($urandom);
  endfunction

  function automatic logic [TIMER_W-1:0] pick_delta(input logic [WINDOW_W-1:0] ticks);
    int unsigned span;
    int          r;
    r    = $urandom_range(0, 99);
    span = ticks / $urandom_range(3, 20);
    if (span > 32767) span = 32767;
    if (span == 0) span = 1;
    if (r < 5) return '0;
    if (r < 10) return '1;
    return 16'($urandom_range(0, 2 * span));
  endfunction

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_item(input logic kind, input logic [CHAN_W-1:0] a,
                           input logic [CHAN_W-1:0] b, input logic [TIMER_W-1:0] t);
    int             gap;
    bit             dropped;
    offset_result_t res;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) >= 60) gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= kind;
    in_ch.chan_a    <= a;
    in_ch.chan_b    <= b;
    in_ch.timer_now <= t;
    do @(posedge clk); while (!in_ch.ready);
    dropped = (kind == REQ_SAMPLE) && !armed;
    if (step_window(kind, a, b, t, res)) pending_offsets.push_back(res);
    if (dropped) n_ignored++;
    else n_taken++;
  endtask

  task automatic send_sample(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b,
                             input logic [TIMER_W-1:0] delta);
    send_item(REQ_SAMPLE, a, b, last_timer + delta);
  endtask

  task automatic settle_block();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (pending_offsets.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_offsets.size() != 0) begin
      $error("%0d offset results never arrived", pending_offsets.size());
      error_count++;
      pending_offsets.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WINDOW_W-1:0] ticks);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= ticks;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    window_ticks = ticks;
    n_settings++;
  endtask

  // reset window length; disarmed samples, wrap, restart while armed
  task automatic test_default_window();
    int i;
    send_item(REQ_SAMPLE, '1, '1, 16'h1234);
    send_item(REQ_START, '1, '1, 16'hFFF0);
    send_item(REQ_SAMPLE, '0, '1, 16'h0010);
    send_item(REQ_SAMPLE, '1, '0, 16'h0010);
    send_item(REQ_START, '0, '0, 16'h8000);
    for (i = 0; i < 8; i++)
      send_sample(i[0] ? 16'h0001 : 16'hFFFF, 16'h8000 ^ 16'(i), 16'hFFFF);
    send_item(REQ_SAMPLE, '1, '0, 16'h0000);
    settle_block();
  endtask

  task automatic test_zero_window();
    write_window('0);
    send_item(REQ_START, '0, '0, 16'h0000);
    send_sample('1, '0, 16'h0000);
    send_item(REQ_SAMPLE, 16'h5555, 16'hAAAA, 16'h0001);
    send_item(REQ_START, 16'hAAAA, 16'h5555, 16'hFFFF);
    send_sample(16'h0001, 16'hFFFE, 16'h0001);
    settle_block();
  endtask

  task automatic test_one_tick_window();
    write_window(24'd1);
    send_item(REQ_START, '0, '0, 16'd100);
    send_sample(16'h7FFF, 16'h8000, 16'h0000);
    send_sample(16'h8000, 16'h7FFF, 16'h0001);
    settle_block();
  endtask

  task automatic test_widest_window();
    int i;
    write_window('1);
    send_item(REQ_START, '0, '0, 16'h0000);
    for (i = 0; i < 257; i++)
      send_sample(reading(), reading(), 16'hFFFF);
    settle_block();
  endtask

  // results held off while closes keep coming: input must stall
  task automatic test_result_backpressure();
    int i;
    write_window(24'd1);
    result_hold_req = 1'b1;
    for (i = 0; i < 12; i++) begin
      send_item(REQ_START, reading(), reading(), 16'($urandom));
      send_sample(reading(), reading(), 16'h0001);
    end
    settle_block();
  endtask

  task automatic run_window_phase(input logic [WINDOW_W-1:0] ticks, input int budget,
                                  input bit quiet);
    int base;
    write_window(ticks);
    no_idle = quiet;
    base = n_taken;
    while (n_taken - base < budget) begin
      if (!armed) begin
        if ($urandom_range(0, 9) == 0)
          send_item(REQ_SAMPLE, reading(), reading(), 16'($urandom));
        else
          send_item(REQ_START, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if ($urandom_range(0, 99) < 3) begin
        send_item(REQ_START, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_sample(reading(), reading(), pick_delta(window_ticks));
      end
    end
    settle_block();
    no_idle = 1'b0;
  endtask

  task automatic test_random_windows();
    run_window_phase(24'($urandom_range(2, 40)), 240, 1'b0);
    run_window_phase(24'($urandom_range(41, 3000)), 240, 1'b0);
    run_window_phase(WINDOW_RESET, 240, 1'b1);
    run_window_phase(24'($urandom_range(3001, 200000)), 240, 1'b0);
    run_window_phase(24'd1, 240, 1'b0);
    run_window_phase(24'($urandom_range(200001, 4000000)), 240, 1'b0);
    run_window_phase(24'($urandom_range(2, 40)), 240, 1'b1);
  endtask

  initial begin : result_ready_gen
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (result_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (RESULT_HOLD_CYCLES) @(posedge clk);
        result_hold_req = 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    offset_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_offsets.size() == 0) begin
        $error("offset result with none pending");
        error_count++;
      end else begin
        want = pending_offsets.pop_front();
        compare_field("offset_a", want.offset_a, out_ch.offset_a);
        compare_field("offset_b", want.offset_b, out_ch.offset_b);
        compare_field("samples_used", want.samples_used, out_ch.samples_used);
        compare_field("count_limited", want.count_limited, out_ch.count_limited);
        n_checked++;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_START;
    in_ch.chan_a    = '0;
    in_ch.chan_b    = '0;
    in_ch.timer_now = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    acc_a           = '0;
    acc_b           = '0;
    pair_count      = '0;
    elapsed         = '0;
    last_timer      = '0;
    armed           = 1'b0;
    window_ticks    = WINDOW_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_window();
    test_zero_window();
    test_one_tick_window();
    test_widest_window();
    test_result_backpressure();
    test_random_windows();
    settle_block();

    $display("Ran %0d accepted items plus %0d samples dropped while disarmed,",
             n_taken, n_ignored);
    $display("over %0d window settings; %0d offset results compared.",
             n_settings, n_checked);
    if (error_count == 0) begin
      $display("dual_adc_offset_averager test passed");
    end else begin
      $display("dual_adc_offset_averager test failed");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("dual_adc_offset_averager test failed");
    $finish;
  end

endmodule

### sim.f
hdl/daoa_pkg.sv
hdl/daoa_if.sv
hdl/daoa_ctrl.sv
hdl/daoa_dp.sv
hdl/dual_adc_offset_averager.sv
hdl/daoa_checker.sv
sim/tb_dual_adc_offset_averager.sv
